>>> hw/rtl/httpcd_pkg.sv
`default_nettype none
package httpcd_pkg;

  localparam int unsigned SizeBitsDefault = 32;

  localparam logic [7:0] ChLf = 8'h0a;
  localparam logic [7:0] ChCr = 8'h0d;

  // bytes dropped after a chunk's data and after the zero-size line
  localparam int unsigned TrailerLen = 2;
  localparam int unsigned SkipLen    = 2;

  localparam logic [1:0] LineOne = 2'd1;
  localparam logic [1:0] LineMax = 2'd3;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_value(input logic [7:0] c);
    hex_digit_t r;
    r.is_hex = 1'b1;
    r.value  = 4'd0;
    if (c inside {[8'h30 : 8'h39]}) begin
      r.value = 4'(c - 8'h30);
    end else if (c inside {[8'h61 : 8'h66]}) begin
      r.value = 4'(c - 8'h61 + 8'd10);
    end else if (c inside {[8'h41 : 8'h46]}) begin
      r.value = 4'(c - 8'h41 + 8'd10);
    end else begin
      r.is_hex = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/httpcd_stream_if.sv
`default_nettype none
interface httpcd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface httpcd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_message;

  modport source (output valid, output out_byte, output end_of_message, input ready);
  modport sink   (input valid, input out_byte, input end_of_message, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/http_chunked_body_decoder_top.sv
`default_nettype none
// Chunked HTTP body decoder. Takes one raw response byte per request on in_i and
// gives the chunk data bytes on out_o, followed by a marker (end_of_message = 1,
// out_byte = 0) when the zero-size chunk arrives. Header lines, chunk-size lines
// and the CRLF after each chunk produce no output. One byte is accepted every
// cycle while in_i.ready is high; a byte passes through the input register and
// then the result register before its result shows on out_o. in_i.ready falls
// only while a result waits on out_o and the input register is also full. Chunk
// sizes above 2**SIZE_BITS-1 saturate.
module http_chunked_body_decoder_top #(
  parameter int unsigned SIZE_BITS = httpcd_pkg::SizeBitsDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  httpcd_byte_if.sink       in_i,
  httpcd_result_if.source   out_o
);

  localparam logic [1:0] MODE_HEADER = 2'd0;
  localparam logic [1:0] MODE_SIZE   = 2'd1;
  localparam logic [1:0] MODE_DATA   = 2'd2;
  localparam logic [1:0] MODE_SKIP   = 2'd3;

  logic                 in_vld_q;
  logic [7:0]           in_byte_q;
  logic                 out_vld_q, out_vld_d;
  logic [7:0]           out_byte_q, out_byte_d;
  logic                 out_eom_q, out_eom_d;
  logic [1:0]           mode_q, mode_d;
  logic [1:0]           line_q, line_d;
  logic [SIZE_BITS-1:0] acc_q, acc_d;
  logic [SIZE_BITS:0]   rem_q, rem_d, rem_dec;
  logic [1:0]           skip_q, skip_d;
  logic                 adv;
  logic                 emit;
  httpcd_pkg::hex_digit_t hd;

  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.in_byte;
    end
  end

  assign hd      = httpcd_pkg::hex_value(in_byte_q);
  assign rem_dec = rem_q - (SIZE_BITS+1)'(1);

  always_comb begin
    mode_d     = mode_q;
    line_d     = line_q;
    acc_d      = acc_q;
    rem_d      = rem_q;
    skip_d     = skip_q;
    emit       = 1'b0;
    out_byte_d = in_byte_q;
    out_eom_d  = 1'b0;
    case (mode_q)
      MODE_HEADER: begin
        if (in_byte_q != httpcd_pkg::ChLf) begin
          if (line_q != httpcd_pkg::LineMax) line_d = line_q + 2'd1;
        end else begin
          if (line_q == httpcd_pkg::LineOne) mode_d = MODE_SIZE;
          line_d = '0;
        end
      end
      MODE_SIZE: begin
        if (in_byte_q != httpcd_pkg::ChLf) begin
          if (hd.is_hex) begin
            // top nibble set means one more digit would overflow
            if (acc_q[SIZE_BITS-1 -: 4] != 4'd0) acc_d = '1;
            else acc_d = {acc_q[SIZE_BITS-5:0], hd.value};
          end
        end else if (acc_q != '0) begin
          rem_d  = {1'b0, acc_q} + (SIZE_BITS+1)'(httpcd_pkg::TrailerLen);
          acc_d  = '0;
          mode_d = MODE_DATA;
        end else begin
          skip_d     = 2'(httpcd_pkg::SkipLen);
          mode_d     = MODE_SKIP;
          emit       = 1'b1;
          out_byte_d = '0;
          out_eom_d  = 1'b1;
        end
      end
      MODE_DATA: begin
        if (rem_q == '0) begin
          mode_d = MODE_SIZE;
        end else begin
          rem_d = rem_dec;
          if (rem_dec == '0) mode_d = MODE_SIZE;
          // trailing crlf of the chunk is dropped
          if (rem_dec >= (SIZE_BITS+1)'(httpcd_pkg::TrailerLen)) emit = 1'b1;
        end
      end
      default: begin
        if (skip_q != 2'd0) skip_d = skip_q - 2'd1;
        if (skip_d == 2'd0) mode_d = MODE_HEADER;
      end
    endcase
  end

  assign out_vld_d = in_vld_q && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_HEADER;
      line_q    <= '0;
      acc_q     <= '0;
      rem_q     <= '0;
      skip_q    <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= out_vld_d;
      if (in_vld_q) begin
        mode_q <= mode_d;
        line_q <= line_d;
        acc_q  <= acc_d;
        rem_q  <= rem_d;
        skip_q <= skip_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && out_vld_d) begin
      out_byte_q <= out_byte_d;
      out_eom_q  <= out_eom_d;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.out_byte       = out_byte_q;
  assign out_o.end_of_message = out_eom_q;

  a_eom_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_eom_q |-> out_byte_q == 8'd0)
    else $error("end marker carries a nonzero byte");

  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_SKIP |-> skip_q != 2'd0)
    else $error("skip mode with empty skip count");

  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_DATA |-> rem_q != '0)
    else $error("data mode with empty remaining count");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |=> $stable(mode_q) && $stable(rem_q))
    else $error("state moved without a byte");

endmodule
`default_nettype wire

>>> tb/httpcd_decode_monitor.sv
module httpcd_decode_monitor (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  httpcd_byte_if    in_if,
  httpcd_result_if  out_if,
  output int        mismatches_o,
  output int        pending_o,
  output int        bytes_seen_o,
  output int        data_seen_o,
  output int        eom_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import httpcd_pkg::*;

  localparam int unsigned SizeBits = SizeBitsDefault;
  localparam logic [SizeBits-1:0] SizeMax = {SizeBits{1'b1}};
  localparam logic [4:0] NotHex = 5'd16;

  typedef enum logic [1:0] {
    ModeHeader,
    ModeSize,
    ModeData,
    ModeSkip
  } parse_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eom;
  } decoded_t;

  parse_mode_e       mode;
  logic [1:0]        line_len;
  logic [SizeBits-1:0] size_acc;
  logic [SizeBits:0] remaining;
  logic [1:0]        skip_left;
  decoded_t          expected_out_q[$];

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
    return NotHex;
  endfunction

  // advances the decoder by one byte, returns 1 when it yields a result
  function automatic bit decode_byte(input logic [7:0] c, output decoded_t r);
    logic [4:0] d;
    r = '0;
    case (mode)
      ModeHeader: begin
        if (c != ChLf) begin
          if (line_len != LineMax) line_len = line_len + 2'd1;
        end else begin
          if (line_len == LineOne) mode = ModeSize;
          line_len = '0;
        end
      end
      ModeSize: begin
        if (c != ChLf) begin
          d = hex_digit(c);
          if (c != ChCr && d != NotHex) begin
            if (size_acc > (SizeMax >> 4)) size_acc = SizeMax;
            else size_acc = (size_acc << 4) + SizeBits'(d);
          end
        end else if (size_acc != '0) begin
          remaining = {1'b0, size_acc} + (SizeBits + 1)'(TrailerLen);
          size_acc  = '0;
          mode      = ModeData;
        end else begin
          skip_left = 2'(SkipLen);
          mode      = ModeSkip;
          r.eom     = 1'b1;
          return 1'b1;
        end
      end
      ModeData: begin
        if (remaining == '0) begin
          mode = ModeSize;
        end else begin
          remaining = remaining - (SizeBits + 1)'(1);
          if (remaining == '0) mode = ModeSize;
          // the last two bytes of a chunk are its trailer
          if (remaining >= (SizeBits + 1)'(TrailerLen)) begin
            r.data = c;
            return 1'b1;
          end
        end
      end
      default: begin
        if (skip_left != '0) skip_left = skip_left - 2'd1;
        if (skip_left == '0) mode = ModeHeader;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic flag_error(input string msg);
    mismatches_o++;
    if (mismatches_o <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin
    decoded_t got;
    decoded_t want;
    decoded_t fresh;
    if (!rst_ni) begin
      mode      = ModeHeader;
      line_len  = '0;
      size_acc  = '0;
      remaining = '0;
      skip_left = '0;
      expected_out_q.delete();
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.data = out_if.out_byte;
        got.eom  = out_if.end_of_message;
        if (got.eom) eom_seen_o++;
        else data_seen_o++;
        if (expected_out_q.size() == 0) begin
          flag_error($sformatf("unexpected result: byte %02h eom %0b at %0t",
                               got.data, got.eom, $realtime));
        end else begin
          want = expected_out_q.pop_front();
          if (got !== want) begin
            flag_error($sformatf(
              "mismatch at %0t: expected byte %02h eom %0b, got byte %02h eom %0b",
              $realtime, want.data, want.eom, got.data, got.eom));
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        bytes_seen_o++;
        if (decode_byte(in_if.in_byte, fresh)) begin
          expected_out_q.insert(expected_out_q.size(), fresh);
        end
      end
    end
    pending_o = expected_out_q.size();
  end

endmodule

>>> tb/tb_http_chunked_body_decoder_top.sv
module tb_http_chunked_body_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import httpcd_pkg::*;

  localparam logic [7:0] ChZero   = "0";
  localparam logic [7:0] ChUpperA = "A";
  localparam logic [7:0] ChLowerA = "a";

  localparam int PhaseBytes = 325;
  localparam int StallCycles = 300;
  localparam int SendIdle [4] = '{0, 77, 0, 14};
  localparam int RecvStall [4] = '{0, 0, 77, 14};

  // empty and saturated header lines, noisy size line, odd trailer, empty size line
  localparam logic [7:0] Opening [20] = '{
    ChLf, "H", "T", "T", ChCr, ChLf, ChCr, ChLf,
    "g", "2", ChCr, ChLf, 8'h00, 8'hff, "x", "y",
    ChCr, ChLf, ChLf, ChCr
  };
  // eight f digits fill the accumulator exactly, the trailing digit clips
  localparam logic [7:0] Oversized [13] = '{
    ChCr, ChLf, "f", "F", "F", "f", "F", "F", "F", "F", "A", ChCr, ChLf
  };

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_left;
  int   bytes_sent;
  int   mismatches;
  int   pending;
  int   bytes_seen;
  int   data_seen;
  int   eom_seen;

  httpcd_byte_if   in_if ();
  httpcd_result_if out_if ();

  http_chunked_body_decoder_top uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  httpcd_decode_monitor decode_mon (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_if       (in_if),
    .out_if      (out_if),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .bytes_seen_o(bytes_seen),
    .data_seen_o (data_seen),
    .eom_seen_o  (eom_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_http_chunked_body_decoder_top failed");
    $finish;
  end

  // result side: long hold-off when requested, random stalls otherwise
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [7:0] any_but_lf();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == ChLf) b = 8'($urandom_range(255));
    return b;
  endfunction

  // a byte the size parser ignores
  function automatic logic [7:0] filler_byte();
    logic [7:0] b;
    b = any_but_lf();
    while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F") ||
           b == ChLf)
      b = 8'($urandom_range(255));
    return b;
  endfunction

  function automatic logic [7:0] hex_char(input int unsigned d);
    if (d < 10) return ChZero + 8'(d);
    return ($urandom_range(1) ? ChUpperA : ChLowerA) + 8'(d - 10);
  endfunction

  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid   = 1'b1;
    in_if.in_byte = b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic push_size_line(input int unsigned size);
    logic [7:0]  text[$];
    int unsigned v;
    bit          no_digits;
    v = size;
    no_digits = (size == 0) && ($urandom_range(4) == 0);
    if (!no_digits) begin
      while (v != 0) begin
        text.push_front(hex_char(v % 16));
        v = v / 16;
      end
      if (size == 0) text.push_front(ChZero);
      repeat ($urandom_range(2)) text.push_front(ChZero);
    end
    if ($urandom_range(9) < 3) text.insert($urandom_range(text.size()), filler_byte());
    foreach (text[i]) push_byte(text[i]);
    if ($urandom_range(9) != 0) push_byte(ChCr);
    push_byte(ChLf);
  endtask

  task automatic push_message();
    int unsigned n;
    int unsigned size;
    repeat ($urandom_range(3)) begin
      n = $urandom_range(6);
      // a one-byte line would end the header early
      if (n == 1) n = 2;
      repeat (n) push_byte(any_but_lf());
      push_byte(ChLf);
    end
    push_byte(($urandom_range(6) == 0) ? any_but_lf() : ChCr);
    push_byte(ChLf);
    repeat ($urandom_range(3)) begin
      size = ($urandom_range(4) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
      push_size_line(size);
      repeat (size) push_byte(8'($urandom_range(255)));
      if ($urandom_range(6) == 0) begin
        push_byte(8'($urandom_range(255)));
        push_byte(8'($urandom_range(255)));
      end else begin
        push_byte(ChCr);
        push_byte(ChLf);
      end
    end
    push_size_line(0);
    if ($urandom_range(3) == 0) begin
      push_byte(8'($urandom_range(255)));
      push_byte(8'($urandom_range(255)));
    end else begin
      push_byte(ChCr);
      push_byte(ChLf);
    end
  endtask

  initial begin
    in_if.valid    = 1'b0;
    in_if.in_byte  = '0;
    rst_n          = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    bytes_sent     = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (Opening[i]) push_byte(Opening[i]);
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = SendIdle[p];
      recv_stall_pct = RecvStall[p];
      if (p == 0) hold_left = StallCycles;
      while (bytes_sent < (p + 1) * PhaseBytes) push_message();
    end
    // leaves the decoder inside a chunk it can never finish
    foreach (Oversized[i]) push_byte(Oversized[i]);
    repeat (24) push_byte(8'($urandom_range(255)));
    in_if.valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d input bytes giving %0d data bytes and %0d message ends,",
             bytes_seen, data_seen, eom_seen);
    $display("over idle-free, sender-idle, receiver-stall and mixed phases plus a long stall");
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_http_chunked_body_decoder_top passed");
    end else begin
      $display("tb_http_chunked_body_decoder_top failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/httpcd_pkg.sv
hw/rtl/httpcd_stream_if.sv
hw/rtl/http_chunked_body_decoder_top.sv
tb/httpcd_decode_monitor.sv
tb/tb_http_chunked_body_decoder_top.sv
